// ===== design/chp_pkg.sv =====
// Shared types and constants for the chunk header parser.
`default_nettype none
package chp_pkg;

  localparam int unsigned ID_W = 17;
  localparam logic [31:0] MARK24 = 32'h00FF_FFFF;
  localparam logic [16:0] ID_OFFSET = 17'd64;
  localparam logic [5:0] ID_CODE_TWO = 6'd0;
  localparam logic [5:0] ID_CODE_THREE = 6'd1;

  localparam logic [1:0] FMT_FULL = 2'd0;
  localparam logic [1:0] FMT_NO_MSID = 2'd1;
  localparam logic [1:0] FMT_TS_ONLY = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic        status;
    logic [1:0]  header_format;
    logic [16:0] chunk_stream;
    logic [31:0] msg_timestamp;
    logic [23:0] msg_length;
    logic [7:0]  msg_type;
    logic [31:0] msg_stream;
  } result_t;

  typedef struct packed {
    logic        err;
    logic [1:0]  fmt;
    logic [16:0] id;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] msid;
  } cmd_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] msid;
  } slot_t;

  typedef struct packed {
    logic        en;
    logic [16:0] id;
  } rd_req_t;

endpackage
`default_nettype wire

// ===== design/chp_if.sv =====
// Stream interfaces for header bytes and parsed header words.
`default_nettype none
interface chp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface chp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [1:0]  header_format;
  logic [16:0] chunk_stream;
  logic [31:0] msg_timestamp;
  logic [23:0] msg_length;
  logic [7:0]  msg_type;
  logic [31:0] msg_stream;

  modport source (output valid, output status, output header_format, output chunk_stream,
                  output msg_timestamp, output msg_length, output msg_type,
                  output msg_stream, input ready);
  modport sink (input valid, input status, input header_format, input chunk_stream,
                input msg_timestamp, input msg_length, input msg_type,
                input msg_stream, output ready);
endinterface
`default_nettype wire

// ===== design/chunk_header_parser_unit.sv =====
// Chunk header parser top level: byte parser, stream table and result queue.
// Throughput: one header byte per cycle; the input stalls only while the four-word result
// queue, counting the word in the table stage, has no free entry.
// A header word passes the table stage, which loads at the edge that accepts its last byte,
// and then the result queue, which loads at the next edge, before it is valid on result_o.
// Reset clears the parser state and the table valid and mark bits; unwritten slots read as
// zero, so no clearing pass is needed and bytes are taken right after reset.
`default_nettype none
module chunk_header_parser_unit #(
  parameter int unsigned STREAM_SLOTS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  chp_byte_if.sink           stream_i,
  chp_result_if.source       result_o
);

  logic              byte_fire;
  logic              mark;
  chp_pkg::rd_req_t  rd;
  logic              cmd_valid;
  chp_pkg::cmd_t     cmd;
  logic              res_valid;
  chp_pkg::result_t  res;
  logic              q_valid;
  chp_pkg::result_t  q_data;
  logic [chp_pkg::QCNT_W-1:0] q_count;

  // Leave room for the word in the table stage and one more from the parser
  assign stream_i.ready = ({1'b0, q_count} + {{chp_pkg::QCNT_W{1'b0}}, res_valid})
                          < (chp_pkg::QCNT_W + 1)'(chp_pkg::QDEPTH);
  assign byte_fire = stream_i.valid && stream_i.ready;

  chp_front #(.STREAM_SLOTS(STREAM_SLOTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_fire),
    .byte_i      (stream_i.stream_byte),
    .mark_i      (mark),
    .rd_o        (rd),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  chp_table #(.STREAM_SLOTS(STREAM_SLOTS)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .mark_o     (mark),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  chp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (result_o.ready),
    .valid_o    (q_valid),
    .data_o     (q_data),
    .count_o    (q_count)
  );

  assign result_o.valid = q_valid;
  assign result_o.status = q_data.status;
  assign result_o.header_format = q_data.header_format;
  assign result_o.chunk_stream = q_data.chunk_stream;
  assign result_o.msg_timestamp = q_data.msg_timestamp;
  assign result_o.msg_length = q_data.msg_length;
  assign result_o.msg_type = q_data.msg_type;
  assign result_o.msg_stream = q_data.msg_stream;

endmodule
`default_nettype wire

// ===== design/chp_front.sv =====
// Byte parser: decodes basic and message headers into header commands.
`default_nettype none
module chp_front #(
  parameter int unsigned STREAM_SLOTS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            byte_valid_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            mark_i,
  output chp_pkg::rd_req_t     rd_o,
  output logic                 cmd_valid_o,
  output chp_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    PH_BASIC, PH_ID1, PH_ID2A, PH_ID2B, PH_TS, PH_LEN, PH_TYPE, PH_MSID, PH_EXT
  } phase_e;

  localparam logic [5:0] ID_CODE_TWO_L = chp_pkg::ID_CODE_TWO;
  localparam logic [5:0] ID_CODE_THREE_L = chp_pkg::ID_CODE_THREE;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [16:0] id_q, id_d;
  logic [31:0] ts_q, ts_d;
  logic [23:0] len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] msid_q, msid_d;

  logic        id_fire, chk, emit;
  logic [16:0] id_now;
  logic [1:0]  fmt_now;
  logic [31:0] chk_ts, emit_ts;

  always_comb begin
    phase_d = phase_q;
    idx_d = idx_q;
    fmt_d = fmt_q;
    id_d = id_q;
    ts_d = ts_q;
    len_d = len_q;
    type_d = type_q;
    msid_d = msid_q;
    id_fire = 1'b0;
    chk = 1'b0;
    emit = 1'b0;
    id_now = id_q;
    fmt_now = fmt_q;
    chk_ts = ts_q;
    emit_ts = ts_q;
    rd_o = '0;
    cmd_valid_o = 1'b0;
    cmd_o = '0;

    if (byte_valid_i) begin
      unique case (phase_q)
        PH_BASIC: begin
          fmt_now = byte_i[7:6];
          fmt_d = fmt_now;
          idx_d = 3'd0;
          if (byte_i[5:0] == ID_CODE_TWO_L) begin
            phase_d = PH_ID1;
          end else if (byte_i[5:0] == ID_CODE_THREE_L) begin
            phase_d = PH_ID2A;
          end else begin
            id_now = {11'd0, byte_i[5:0]};
            id_fire = 1'b1;
          end
        end
        PH_ID1: begin
          id_now = {9'd0, byte_i} + chp_pkg::ID_OFFSET;
          id_fire = 1'b1;
        end
        PH_ID2A: begin
          id_d = {9'd0, byte_i};
          phase_d = PH_ID2B;
        end
        PH_ID2B: begin
          id_now = {1'b0, byte_i, 8'd0} + id_q + chp_pkg::ID_OFFSET;
          id_fire = 1'b1;
        end
        PH_TS: begin
          ts_d = {8'd0, ts_q[15:0], byte_i};
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd2) begin
            idx_d = 3'd0;
            if (fmt_q == chp_pkg::FMT_FULL || fmt_q == chp_pkg::FMT_NO_MSID) begin
              phase_d = PH_LEN;
            end else begin
              chk = 1'b1;
              chk_ts = ts_d;
            end
          end
        end
        PH_LEN: begin
          len_d = {len_q[15:0], byte_i};
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd2) begin
            idx_d = 3'd0;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d = byte_i;
          if (fmt_q == chp_pkg::FMT_FULL) begin
            phase_d = PH_MSID;
            idx_d = 3'd0;
            msid_d = '0;
          end else begin
            chk = 1'b1;
          end
        end
        PH_MSID: begin
          msid_d = msid_q | (32'(byte_i) << {idx_q[1:0], 3'b000});
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            chk = 1'b1;
          end
        end
        PH_EXT: begin
          ts_d = {ts_q[23:0], byte_i};
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            emit = 1'b1;
            emit_ts = ts_d;
          end
        end
        default: begin
          phase_d = PH_BASIC;
          idx_d = 3'd0;
        end
      endcase
    end

    if (id_fire) begin
      id_d = id_now;
      if (32'(id_now) >= 32'(STREAM_SLOTS)) begin
        // Unknown stream: report at once, drop the rest of the header
        cmd_valid_o = 1'b1;
        cmd_o.err = 1'b1;
        cmd_o.fmt = fmt_now;
        cmd_o.id = id_now;
        phase_d = PH_BASIC;
        idx_d = 3'd0;
      end else begin
        rd_o.en = 1'b1;
        rd_o.id = id_now;
        ts_d = '0;
        idx_d = 3'd0;
        if (fmt_now != chp_pkg::FMT_NONE) begin
          phase_d = PH_TS;
        end else begin
          chk = 1'b1;
          chk_ts = '0;
        end
      end
    end

    if (chk) begin
      if ((fmt_now == chp_pkg::FMT_NONE && mark_i) || chk_ts == chp_pkg::MARK24) begin
        phase_d = PH_EXT;
        idx_d = 3'd0;
        ts_d = '0;
      end else begin
        emit = 1'b1;
        emit_ts = chk_ts;
      end
    end

    if (emit) begin
      cmd_valid_o = 1'b1;
      cmd_o.err = 1'b0;
      cmd_o.fmt = fmt_now;
      cmd_o.id = id_d;
      cmd_o.ts = emit_ts;
      cmd_o.len = len_d;
      cmd_o.typ = type_d;
      cmd_o.msid = msid_d;
      phase_d = PH_BASIC;
      idx_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BASIC;
      idx_q <= '0;
      fmt_q <= '0;
      id_q <= '0;
      ts_q <= '0;
      len_q <= '0;
      type_q <= '0;
      msid_q <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q <= idx_d;
      fmt_q <= fmt_d;
      id_q <= id_d;
      ts_q <= ts_d;
      len_q <= len_d;
      type_q <= type_d;
      msid_q <= msid_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/chp_table.sv =====
// Per-stream table: resolves header commands against stored slot state.
`default_nettype none
module chp_table #(
  parameter int unsigned STREAM_SLOTS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire chp_pkg::rd_req_t rd_i,
  output logic                  mark_o,
  input  wire logic             cmd_valid_i,
  input  wire chp_pkg::cmd_t    cmd_i,
  output logic                  res_valid_o,
  output chp_pkg::result_t      res_o
);

  localparam int unsigned AW = $clog2(STREAM_SLOTS);

  chp_pkg::slot_t mem [STREAM_SLOTS];
  logic [STREAM_SLOTS-1:0] valid_q;
  logic [STREAM_SLOTS-1:0] mark_q;

  logic           exec_v_q;
  chp_pkg::cmd_t  exec_q;
  chp_pkg::slot_t rd_data_q;

  chp_pkg::slot_t wdata;
  logic           wr_en, fwd;
  logic [AW-1:0]  waddr, raddr;

  assign waddr = exec_q.id[AW-1:0];
  assign raddr = rd_i.id[AW-1:0];
  assign wr_en = exec_v_q && !exec_q.err;
  assign fwd = wr_en && (waddr == raddr);

  always_comb begin
    wdata.ts = (exec_q.fmt == chp_pkg::FMT_FULL) ? exec_q.ts : rd_data_q.ts + exec_q.ts;
    if (exec_q.fmt == chp_pkg::FMT_FULL || exec_q.fmt == chp_pkg::FMT_NO_MSID) begin
      wdata.len = exec_q.len;
      wdata.typ = exec_q.typ;
    end else begin
      wdata.len = rd_data_q.len;
      wdata.typ = rd_data_q.typ;
    end
    wdata.msid = (exec_q.fmt == chp_pkg::FMT_FULL) ? exec_q.msid : rd_data_q.msid;
  end

  // Bypass the slot being written this cycle
  assign mark_o = fwd ? (wdata.ts == chp_pkg::MARK24) : mark_q[raddr];

  always_comb begin
    res_valid_o = exec_v_q;
    res_o.status = exec_q.err;
    res_o.header_format = exec_q.fmt;
    res_o.chunk_stream = exec_q.id;
    if (exec_q.err) begin
      res_o.msg_timestamp = '0;
      res_o.msg_length = '0;
      res_o.msg_type = '0;
      res_o.msg_stream = '0;
    end else begin
      res_o.msg_timestamp = wdata.ts;
      res_o.msg_length = wdata.len;
      res_o.msg_type = wdata.typ;
      res_o.msg_stream = wdata.msid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (exec_v_q == 1'b0 || cmd_valid_i) begin
      exec_q <= cmd_i;
    end
    if (rd_i.en) begin
      if (fwd) begin
        rd_data_q <= wdata;
      end else if (valid_q[raddr]) begin
        rd_data_q <= mem[raddr];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mark_q <= '0;
      exec_v_q <= 1'b0;
    end else begin
      exec_v_q <= cmd_valid_i;
      if (wr_en) begin
        valid_q[waddr] <= 1'b1;
        mark_q[waddr] <= (wdata.ts == chp_pkg::MARK24);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/chp_fifo.sv =====
// Result queue between the table stage and the output port.
`default_nettype none
module chp_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire chp_pkg::result_t            push_data_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output chp_pkg::result_t                 data_o,
  output logic [chp_pkg::QCNT_W-1:0]       count_o
);

  localparam int unsigned QCNT_W = chp_pkg::QCNT_W;

  chp_pkg::result_t store_q [chp_pkg::QDEPTH];
  logic [chp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [chp_pkg::QCNT_W-1:0] count_q;
  logic do_pop;

  assign valid_o = (count_q != '0);
  assign data_o = store_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== dv/chp_checker.sv =====
// Checker for the chunk header parser: tracks byte and result channels, predicts and compares.
`default_nettype none
module chp_checker #(
  parameter int unsigned STREAM_SLOTS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  chp_byte_if         stream_i,
  chp_result_if       result_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [3:0] {
    PH_BASIC, PH_ID1, PH_ID2A, PH_ID2B, PH_TS, PH_LEN, PH_TYPE, PH_MSID, PH_EXT
  } phase_e;

  phase_e             phase;
  int unsigned        idx;
  logic [1:0]         fmt;
  logic [16:0]        id;
  logic [31:0]        tacc;
  logic [23:0]        len_w;
  logic [7:0]         typ_w;
  logic [31:0]        msid_w;
  chp_pkg::slot_t     slots [STREAM_SLOTS];
  chp_pkg::result_t   header_q [$];
  int unsigned        fails;

  assign fail_count_o = fails;
  assign pending_o = header_q.size();

  task automatic finish_header();
    logic [31:0] ts;
    chp_pkg::result_t r;
    ts = (fmt == chp_pkg::FMT_FULL) ? tacc : slots[id].ts + tacc;
    slots[id] = '{ts: ts, len: len_w, typ: typ_w, msid: msid_w};
    r = '{status: 1'b0, header_format: fmt, chunk_stream: id, msg_timestamp: ts,
          msg_length: len_w, msg_type: typ_w, msg_stream: msid_w};
    header_q.push_back(r);
    phase = PH_BASIC;
    idx = 0;
  endtask

  task automatic check_extension();
    if ((fmt == chp_pkg::FMT_NONE && slots[id].ts == chp_pkg::MARK24) ||
        tacc == chp_pkg::MARK24) begin
      phase = PH_EXT;
      idx = 0;
      tacc = '0;
    end else begin
      finish_header();
    end
  endtask

  task automatic id_complete();
    chp_pkg::result_t r;
    if (id >= STREAM_SLOTS) begin
      r = '0;
      r.status = 1'b1;
      r.header_format = fmt;
      r.chunk_stream = id;
      header_q.push_back(r);
      phase = PH_BASIC;
      idx = 0;
    end else begin
      tacc = '0;
      len_w = slots[id].len;
      typ_w = slots[id].typ;
      msid_w = slots[id].msid;
      if (fmt != chp_pkg::FMT_NONE) begin
        phase = PH_TS;
        idx = 0;
      end else begin
        check_extension();
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (phase)
      PH_BASIC: begin
        fmt = b[7:6];
        if (b[5:0] != chp_pkg::ID_CODE_TWO && b[5:0] != chp_pkg::ID_CODE_THREE) begin
          id = {11'd0, b[5:0]};
          id_complete();
        end else begin
          phase = (b[5:0] == chp_pkg::ID_CODE_TWO) ? PH_ID1 : PH_ID2A;
          idx = 0;
        end
      end
      PH_ID1: begin
        id = {9'd0, b} + chp_pkg::ID_OFFSET;
        id_complete();
      end
      PH_ID2A: begin
        id = {9'd0, b};
        phase = PH_ID2B;
      end
      PH_ID2B: begin
        id = {1'b0, b, 8'd0} + id + chp_pkg::ID_OFFSET;
        id_complete();
      end
      PH_TS: begin
        tacc = {8'd0, tacc[15:0], b};
        idx++;
        if (idx == 3) begin
          if (fmt == chp_pkg::FMT_FULL || fmt == chp_pkg::FMT_NO_MSID) begin
            phase = PH_LEN;
            idx = 0;
            len_w = '0;
          end else begin
            check_extension();
          end
        end
      end
      PH_LEN: begin
        len_w = {len_w[15:0], b};
        idx++;
        if (idx == 3) begin
          phase = PH_TYPE;
          idx = 0;
        end
      end
      PH_TYPE: begin
        typ_w = b;
        if (fmt == chp_pkg::FMT_FULL) begin
          phase = PH_MSID;
          idx = 0;
          msid_w = '0;
        end else begin
          check_extension();
        end
      end
      PH_MSID: begin
        msid_w[8*idx +: 8] = b;
        idx++;
        if (idx == 4) check_extension();
      end
      PH_EXT: begin
        tacc = {tacc[23:0], b};
        idx++;
        if (idx == 4) finish_header();
      end
      default: begin
        phase = PH_BASIC;
        idx = 0;
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    fails++;
    if (fails <= 10)
      $display("mismatch %s: expected %h actual %h at %0t", what, want, got, $realtime);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chp_pkg::result_t got, want;
    if (!rst_ni) begin
      phase = PH_BASIC;
      idx = 0;
      fmt = '0;
      id = '0;
      tacc = '0;
      len_w = '0;
      typ_w = '0;
      msid_w = '0;
      foreach (slots[i]) slots[i] = '0;
      header_q.delete();
      fails = 0;
    end else begin
      // compare first: a header finished this edge cannot already be on the output
      if (result_o.valid && result_o.ready) begin
        got = '{status: result_o.status, header_format: result_o.header_format,
                chunk_stream: result_o.chunk_stream, msg_timestamp: result_o.msg_timestamp,
                msg_length: result_o.msg_length, msg_type: result_o.msg_type,
                msg_stream: result_o.msg_stream};
        if (header_q.size() == 0) begin
          report("unexpected word", '0, {15'd0, got.chunk_stream});
        end else begin
          want = header_q.pop_front();
          if (got.status != want.status)
            report("status", 32'(want.status), 32'(got.status));
          if (got.header_format != want.header_format)
            report("header_format", 32'(want.header_format), 32'(got.header_format));
          if (got.chunk_stream != want.chunk_stream)
            report("chunk_stream", 32'(want.chunk_stream), 32'(got.chunk_stream));
          if (got.msg_timestamp != want.msg_timestamp)
            report("msg_timestamp", want.msg_timestamp, got.msg_timestamp);
          if (got.msg_length != want.msg_length)
            report("msg_length", 32'(want.msg_length), 32'(got.msg_length));
          if (got.msg_type != want.msg_type)
            report("msg_type", 32'(want.msg_type), 32'(got.msg_type));
          if (got.msg_stream != want.msg_stream)
            report("msg_stream", want.msg_stream, got.msg_stream);
        end
      end
      if (stream_i.valid && stream_i.ready) take_byte(stream_i.stream_byte);
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_chunk_header_parser_unit.sv =====
// Testbench top for the chunk header parser: byte stimulus, receiver stalls and verdict.
`default_nettype none
module tb_chunk_header_parser_unit;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  logic [7:0]  byte_q [$];
  logic        long_hold;

  chp_byte_if   stream_if ();
  chp_result_if result_if ();

  chunk_header_parser_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stream_i (stream_if.sink),
    .result_o (result_if.source)
  );

  chp_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stream_i     (stream_if),
    .result_o     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] basic_byte(input logic [1:0] f, input logic [5:0] low);
    return {f, low};
  endfunction

  // Queue one complete header; id_form: 0 one-byte, 1 two-byte, 2 three-byte.
  task automatic queue_header(input logic [1:0] f, input int unsigned id_form,
                              input logic [15:0] id_bytes, input logic [23:0] ts24,
                              input logic [31:0] ext, input logic need_ext);
    logic [5:0] low;
    low = (id_form == 0) ? ((id_bytes[5:0] < 2) ? 6'd2 : id_bytes[5:0]) :
          (id_form == 1) ? chp_pkg::ID_CODE_TWO : chp_pkg::ID_CODE_THREE;
    byte_q.push_back(basic_byte(f, low));
    if (id_form >= 1) byte_q.push_back(id_bytes[7:0]);
    if (id_form == 2) byte_q.push_back(id_bytes[15:8]);
    if (id_form != 0) return;  // long ids land outside the table
    if (f != chp_pkg::FMT_NONE) begin
      byte_q.push_back(ts24[23:16]);
      byte_q.push_back(ts24[15:8]);
      byte_q.push_back(ts24[7:0]);
    end
    if (f == chp_pkg::FMT_FULL || f == chp_pkg::FMT_NO_MSID)
      repeat (4) byte_q.push_back(8'($urandom));
    if (f == chp_pkg::FMT_FULL) repeat (4) byte_q.push_back(8'($urandom));
    if (need_ext) begin
      byte_q.push_back(ext[31:24]);
      byte_q.push_back(ext[23:16]);
      byte_q.push_back(ext[15:8]);
      byte_q.push_back(ext[7:0]);
    end
  endtask

  initial begin
    logic [1:0]  f;
    logic [23:0] ts;
    logic        ext;
    rst_ni = 1'b0;
    stream_if.valid = 1'b0;
    stream_if.stream_byte = '0;
    // directed: all formats, id forms, extended stamps, format 3 on a slot that last took an extended stamp
    queue_header(chp_pkg::FMT_FULL, 0, 16'd2, 24'h000000, '0, 1'b0);
    queue_header(chp_pkg::FMT_FULL, 0, 16'd63, chp_pkg::MARK24[23:0], 32'hFFFF_FFFF, 1'b1);
    queue_header(chp_pkg::FMT_NONE, 0, 16'd63, '0, 32'h0000_0001, 1'b1);
    queue_header(chp_pkg::FMT_NO_MSID, 0, 16'd63, 24'h000005, '0, 1'b0);
    queue_header(chp_pkg::FMT_TS_ONLY, 0, 16'd63, 24'hFFFFFE, '0, 1'b0);
    queue_header(chp_pkg::FMT_NONE, 0, 16'd2, '0, '0, 1'b0);
    queue_header(chp_pkg::FMT_TS_ONLY, 0, 16'd10, chp_pkg::MARK24[23:0], 32'h8000_0000, 1'b1);
    queue_header(chp_pkg::FMT_FULL, 1, 16'h0000, '0, '0, 1'b0);
    queue_header(chp_pkg::FMT_NONE, 1, 16'h00FF, '0, '0, 1'b0);
    queue_header(chp_pkg::FMT_NO_MSID, 2, 16'h0000, '0, '0, 1'b0);
    queue_header(chp_pkg::FMT_TS_ONLY, 2, 16'hFFFF, '0, '0, 1'b0);
    queue_header(chp_pkg::FMT_FULL, 0, 16'd30, 24'hAA5533, '0, 1'b0);
    repeat (70) begin
      f = 2'($urandom);
      ts = ($urandom_range(0, 5) == 0) ? chp_pkg::MARK24[23:0] : 24'($urandom);
      ext = (f != chp_pkg::FMT_NONE && ts == chp_pkg::MARK24[23:0]);
      case ($urandom_range(0, 19))
        0: queue_header(f, 1, 16'($urandom), ts, $urandom, 1'b0);
        1: queue_header(f, 2, 16'($urandom), ts, $urandom, 1'b0);
        // raw noise byte: may desync, checker follows whatever the block parses
        2: byte_q.push_back(8'($urandom));
        default: queue_header(f, 0, 16'($urandom_range(2, 63)), ts, $urandom, ext);
      endcase
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    while (byte_q.size() > 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) begin
        stream_if.valid <= 1'b0;
        @(negedge clk_i);
      end
      repeat ($urandom_range(1, 20)) begin
        if (byte_q.size() > 0) begin
          stream_if.valid <= 1'b1;
          stream_if.stream_byte <= byte_q[0];
          @(posedge clk_i);
          while (!stream_if.ready) @(posedge clk_i);
          void'(byte_q.pop_front());
          @(negedge clk_i);
        end
      end
    end
    stream_if.valid <= 1'b0;
    // let any incomplete trailing header drain; wait for all words
    fork
      while (pending != 0) @(posedge clk_i);
      begin
        #300000;
      end
    join_any
    disable fork;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: own stall pattern plus one long hold-off early in the random part
  initial begin
    int unsigned cyc;
    result_if.ready = 1'b0;
    long_hold = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      long_hold = (cyc >= 300 && cyc < 500);
      if (long_hold) result_if.ready <= 1'b0;
      else if (cyc % 97 < 30) result_if.ready <= 1'b1;
      else result_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/chp_pkg.sv
design/chp_if.sv
design/chp_front.sv
design/chp_table.sv
design/chp_fifo.sv
design/chunk_header_parser_unit.sv
dv/chp_checker.sv
dv/tb_chunk_header_parser_unit.sv
